// File: sv/bae_pkg.sv
`default_nettype none

package bae_pkg;

    // Bound widths and reset values
    localparam int BoundW = 32;
    localparam int HalfW = 16;
    localparam int ByteW = 8;
    localparam logic [BoundW-1:0] LowReset = '0;
    localparam logic [BoundW-1:0] HighReset = '1;
    localparam logic [ByteW-1:0] FillByte = '1;

    // At most this many common-byte shifts per item
    localparam int MaxShifts = 4;
    localparam int CntW = 2;

    // Input action codes
    localparam logic ActEncode = 1'b0;
    localparam logic ActFlush = 1'b1;

    typedef struct packed {
        logic        action;
        logic        bit_value;
        logic [15:0] weight;
    } bae_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_message;
    } bae_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_prod;
        logic update;
        logic shift;
        logic reset_bounds;
        logic out_load;
        logic out_last;
        logic out_eom;
    } bae_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic top_equal;
        logic next_equal;
        logic split_equal;
        logic out_free;
    } bae_stat_t;

endpackage

`default_nettype wire

// File: sv/bae_dp.sv
`default_nettype none

module bae_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bae_pkg::bae_in_t  in_data,
    input  wire bae_pkg::bae_cmd_t cmd,
    output bae_pkg::bae_stat_t     stat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bae_pkg::bae_out_t      out_data
);
    import bae_pkg::*;

    logic [BoundW-1:0] low_reg, low_next;
    logic [BoundW-1:0] high_reg, high_next;
    logic [BoundW-1:0] prod_hi_reg, prod_lo_reg;
    logic              bit_reg;
    logic              out_valid_reg, out_valid_next;
    bae_out_t          out_reg, out_next;

    logic [BoundW-1:0] range_w;
    logic [BoundW-1:0] split_w;
    logic [BoundW-1:0] low_upd, high_upd;
    logic [BoundW-1:0] low_shl, high_shl;

    // Interval width and the split point from the registered partial products
    assign range_w = high_reg - low_reg;
    assign split_w = low_reg + prod_hi_reg + {{HalfW{1'b0}}, prod_lo_reg[BoundW-1:HalfW]};

    always_comb
    begin
        low_upd = low_reg;
        high_upd = high_reg;
        if (bit_reg)
        begin
            high_upd = split_w;
        end
        else
        begin
            low_upd = split_w + BoundW'(1);
        end
    end

    // Bounds after one byte shift
    assign low_shl = {low_reg[BoundW-ByteW-1:0], {ByteW{1'b0}}};
    assign high_shl = {high_reg[BoundW-ByteW-1:0], FillByte};

    assign stat.top_equal = (low_reg[BoundW-1 -: ByteW] == high_reg[BoundW-1 -: ByteW]);
    assign stat.next_equal = (low_shl[BoundW-1 -: ByteW] == high_shl[BoundW-1 -: ByteW]);
    assign stat.split_equal = (low_upd[BoundW-1 -: ByteW] == high_upd[BoundW-1 -: ByteW]);
    assign stat.out_free = !out_valid_reg || out_ready;

    // Next bound values
    always_comb
    begin
        low_next = low_reg;
        high_next = high_reg;
        if (cmd.reset_bounds)
        begin
            low_next = LowReset;
            high_next = HighReset;
        end
        else if (cmd.update)
        begin
            low_next = low_upd;
            high_next = high_upd;
        end
        else if (cmd.shift)
        begin
            low_next = low_shl;
            high_next = high_shl;
        end
    end

    // Output register: loads a byte, clears when the transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_next.out_byte = high_reg[BoundW-1 -: ByteW];
            out_next.last_of_run = cmd.out_last;
            out_next.end_of_message = cmd.out_eom;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= LowReset;
            high_reg <= HighReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_reg <= low_next;
            high_reg <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Partial products and the bit are captured when the item is taken
    always_ff @(posedge clk)
    begin
        if (cmd.load_prod)
        begin
            prod_hi_reg <= range_w[BoundW-1:HalfW] * in_data.weight;
            prod_lo_reg <= range_w[HalfW-1:0] * in_data.weight;
            bit_reg <= in_data.bit_value;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_reset_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reset_bounds |=> (low_reg == LowReset && high_reg == HighReset))
        else $error("bounds not restored after flush");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

endmodule

`default_nettype wire

// File: sv/bae_ctrl.sv
`default_nettype none

module bae_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_action,
    input  wire bae_pkg::bae_stat_t stat,
    output bae_pkg::bae_cmd_t       cmd
);
    import bae_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_UPD   = 4'b0010,
        S_EMIT  = 4'b0100,
        S_FINAL = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            flush_reg, flush_next;
    logic            take;
    logic            run_done;

    assign in_ready = (state_reg == S_IDLE);
    assign take = in_valid && in_ready;

    // The emission run ends on the last allowed shift or when top bytes part
    assign run_done = (cnt_reg == CntW'(MaxShifts - 1)) || !stat.next_equal;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        flush_next = flush_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cnt_next = '0;
                    flush_next = (in_action == ActFlush);
                    if (in_action == ActEncode)
                    begin
                        cmd.load_prod = 1'b1;
                        state_next = S_UPD;
                    end
                    else if (stat.top_equal)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = stat.split_equal ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = run_done && !flush_reg;
                    cmd.shift = 1'b1;
                    if (run_done)
                    begin
                        state_next = flush_reg ? S_FINAL : S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CntW'(1);
                    end
                end
            end
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_eom = 1'b1;
                    cmd.reset_bounds = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            flush_reg <= flush_next;
        end
    end

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("flush did not end after the end-of-message byte");

    a_upd_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |=> (state_reg != S_UPD))
        else $error("bound update repeated");

endmodule

`default_nettype wire

// File: sv/binary_arithmetic_encoder.sv
`default_nettype none

// Carry-less binary arithmetic encoder with 32-bit bounds. Each input
// transfer either encodes one bit with a 16-bit probability-of-one weight or
// flushes the message; every output transfer carries one byte, flagged on the
// final byte an item causes and on the end-of-message byte of a flush. An
// encode item first registers the two 16x16 partial products of the range
// and weight when it is taken, and the bounds update in the next cycle. Each
// emitted byte then takes a step of its own (up to four per item), held off
// while the output register is still full. A flush emits one byte per common
// top byte and then the end-of-message byte. One item is in work at a time;
// the next is taken once the controller is back to idle.
module binary_arithmetic_encoder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bae_pkg::bae_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output bae_pkg::bae_out_t     out_data
);
    import bae_pkg::*;

    bae_cmd_t  cmd;
    bae_stat_t stat;

    bae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_action (in_data.action),
        .stat      (stat),
        .cmd       (cmd)
    );

    bae_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
